### hdl/sensor_moving_average_macros.svh
// Assertion macros for the moving average block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SENSOR_MOVING_AVERAGE_MACROS_SVH
`define SENSOR_MOVING_AVERAGE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked on every rising edge outside reset.
`define SMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// Next-cycle implication, checked on every rising edge outside reset.
`define SMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define SMA_ASSERT_IMP(lbl, ante, cons)
`define SMA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### hdl/sma_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sma_pkg;

  localparam int TEMP_W    = 15;
  localparam int PRES_W    = 17;
  localparam int ALT_W     = 16;
  localparam int SAMPLES_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;
    logic read;
    logic div_start;
    logic div_step;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic read_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### hdl/sensor_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

// Boxcar moving average over the last RING_DEPTH sensor samples. Each request
// carries one compensated sample (temperature in hundredths of a degree,
// pressure in pascals, altitude in metres); the block stores it in a ring,
// then returns one result holding the mean of each channel over the samples
// held so far (up to RING_DEPTH) and that count. Means truncate toward zero.
// Flow: the ring memory gives one held entry per cycle to the summing pass,
// then three restoring dividers run side by side, each in ACC_W one-bit
// steps, ACC_W = 17 + clog2(RING_DEPTH+1) + 1. A finished result sits in
// an output register, so a new request is taken while it waits downstream.
module sensor_moving_average #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [sma_pkg::TEMP_W-1:0]   temperature,
  input  wire logic        [sma_pkg::PRES_W-1:0]   pressure,
  input  wire logic signed [sma_pkg::ALT_W-1:0]    altitude,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [sma_pkg::TEMP_W-1:0]   mean_temperature,
  output logic             [sma_pkg::PRES_W-1:0]   mean_pressure,
  output logic signed      [sma_pkg::ALT_W-1:0]    mean_altitude,
  output logic             [sma_pkg::SAMPLES_W-1:0] samples_held
);

  import sma_pkg::*;

`include "sensor_moving_average_macros.svh"

  cmd_t    cmd;
  status_t status;

  // Sequencer: accept, sum pass, divide, hand result to the output register.
  sma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Ring memory, accumulators, dividers and the output register.
  sma_datapath #(.RING_DEPTH(RING_DEPTH)) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .temperature      (temperature),
    .pressure         (pressure),
    .altitude         (altitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mean_temperature (mean_temperature),
    .mean_pressure    (mean_pressure),
    .mean_altitude    (mean_altitude),
    .samples_held     (samples_held)
  );

  // A taken request always leaves the block busy for the next cycle.
  `SMA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // Never overwrite a result that is still waiting downstream.
  `SMA_ASSERT_IMP(a_load_when_free, cmd.result_load, status.out_free)
  // No sum or divide work while requests are open.
  `SMA_ASSERT_IMP(a_idle_no_work, !in_stall, !cmd.read && !cmd.div_step)
  // A new result shows up only from a result load.
  `SMA_ASSERT_IMP(a_valid_from_load, $rose(out_valid), $past(cmd.result_load))

endmodule

`default_nettype wire

### hdl/sma_div.sv
`timescale 1ns / 1ps
`default_nettype none

module sma_div #(
  parameter int ACC_W = 23,
  parameter int DIV_W = 5
) (
  input  wire logic                    clk,
  input  wire logic                    start,
  input  wire logic                    step,
  input  wire logic signed [ACC_W-1:0] dividend,
  input  wire logic        [DIV_W-1:0] divisor,
  output logic             [ACC_W-1:0] quotient
);

  logic [ACC_W-1:0] quo;
  logic [DIV_W-1:0] rem;
  logic             neg;

  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_diff;
  logic             fits;

  // One restoring step per cycle while step is high, on the magnitude; sign is applied at the end.
  assign rem_sh   = {rem, quo[ACC_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign fits     = (rem_sh >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[ACC_W-1];
      quo <= dividend[ACC_W-1] ? (-dividend) : dividend;
      rem <= '0;
    end else if (step) begin
      quo <= {quo[ACC_W-2:0], fits};
      rem <= fits ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  assign quotient = neg ? (-quo) : quo;

endmodule

`default_nettype wire

### hdl/sma_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sma_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire sma_pkg::status_t status,
  output sma_pkg::cmd_t        cmd
);

  import sma_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (status.read_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (status.div_done) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_READ: begin
        cmd.read = 1'b1;
      end
      ST_DRAIN: begin
        cmd = '0;
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
      end
      ST_HOLD: begin
        cmd.result_load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/sma_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sma_datapath #(
  parameter int RING_DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire sma_pkg::cmd_t                       cmd,
  output sma_pkg::status_t                         status,
  input  wire logic signed [sma_pkg::TEMP_W-1:0]   temperature,
  input  wire logic        [sma_pkg::PRES_W-1:0]   pressure,
  input  wire logic signed [sma_pkg::ALT_W-1:0]    altitude,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed      [sma_pkg::TEMP_W-1:0]   mean_temperature,
  output logic             [sma_pkg::PRES_W-1:0]   mean_pressure,
  output logic signed      [sma_pkg::ALT_W-1:0]    mean_altitude,
  output logic             [sma_pkg::SAMPLES_W-1:0] samples_held
);

  import sma_pkg::*;

  localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int ACC_W  = PRES_W + CNT_W + 1;
  localparam int STEP_W = $clog2(ACC_W);
  localparam int MEM_W  = TEMP_W + PRES_W + ALT_W;

  logic [MEM_W-1:0]        ring [RING_DEPTH];
  logic [MEM_W-1:0]        rd_word;
  logic [SLOT_W-1:0]       write_slot;
  logic [SLOT_W-1:0]       write_slot_next;
  logic [CNT_W-1:0]        fill_count;
  logic [CNT_W-1:0]        fill_count_next;
  logic [SLOT_W-1:0]       rd_idx;
  logic                    rd_pending;
  logic [STEP_W-1:0]       div_cnt;
  logic signed [ACC_W-1:0] acc_t;
  logic signed [ACC_W-1:0] acc_p;
  logic signed [ACC_W-1:0] acc_a;
  logic [ACC_W-1:0]        quo_t;
  logic [ACC_W-1:0]        quo_p;
  logic [ACC_W-1:0]        quo_a;
  logic [CNT_W+SAMPLES_W-1:0] fill_ext;

  logic [TEMP_W-1:0] rd_t;
  logic [PRES_W-1:0] rd_p;
  logic [ALT_W-1:0]  rd_a;

  assign {rd_t, rd_p, rd_a} = rd_word;

  assign write_slot_next = (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                   : write_slot + 1'b1;
  assign fill_count_next = (fill_count == CNT_W'(RING_DEPTH)) ? fill_count
                                                              : fill_count + 1'b1;

  assign status.read_last = ((CNT_W'(rd_idx) + CNT_W'(1)) == fill_count);
  assign status.div_done  = (div_cnt == STEP_W'(ACC_W - 1));
  assign status.out_free  = !out_valid || !out_stall;

  // Ring storage: write on accept, registered read during the sum pass.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[write_slot] <= {temperature, pressure, altitude};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rd_word <= ring[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      rd_idx     <= '0;
      rd_pending <= 1'b0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        write_slot <= write_slot_next;
        fill_count <= fill_count_next;
        rd_idx     <= '0;
      end else if (cmd.read) begin
        rd_idx <= rd_idx + 1'b1;
      end
      rd_pending <= cmd.read;
      if (cmd.div_start) begin
        div_cnt <= '0;
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.result_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Accumulate one slot per cycle, in the cycle after its read.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_t <= '0;
      acc_p <= '0;
      acc_a <= '0;
    end else if (rd_pending) begin
      acc_t <= acc_t + {{(ACC_W - TEMP_W){rd_t[TEMP_W-1]}}, rd_t};
      acc_p <= acc_p + {{(ACC_W - PRES_W){1'b0}}, rd_p};
      acc_a <= acc_a + {{(ACC_W - ALT_W){rd_a[ALT_W-1]}}, rd_a};
    end
  end

  sma_div #(.ACC_W(ACC_W), .DIV_W(CNT_W)) u_div_t (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (acc_t),
    .divisor  (fill_count),
    .quotient (quo_t)
  );

  sma_div #(.ACC_W(ACC_W), .DIV_W(CNT_W)) u_div_p (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (acc_p),
    .divisor  (fill_count),
    .quotient (quo_p)
  );

  sma_div #(.ACC_W(ACC_W), .DIV_W(CNT_W)) u_div_a (
    .clk      (clk),
    .start    (cmd.div_start),
    .step     (cmd.div_step),
    .dividend (acc_a),
    .divisor  (fill_count),
    .quotient (quo_a)
  );

  assign fill_ext = {{SAMPLES_W{1'b0}}, fill_count};

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      mean_temperature <= quo_t[TEMP_W-1:0];
      mean_pressure    <= quo_p[PRES_W-1:0];
      mean_altitude    <= quo_a[ALT_W-1:0];
      samples_held     <= fill_ext[SAMPLES_W-1:0];
    end
  end

endmodule

`default_nettype wire

### tb/sensor_moving_average_test.sv
`timescale 1ns / 1ps

// Each request carries one sample. The block keeps the last RING_DEPTH
// samples and returns one result per request. That result holds the mean of
// each channel over the samples held so far, and the count of those samples.
module sensor_moving_average_test;
  import sma_pkg::*;

  localparam int RING_DEPTH      = 16;
  localparam int RANDOM_REQUESTS = 600;
  localparam int QUIET_TAIL      = 80;    // requests at the end sent with no idling
  localparam int HOLD_AFTER      = 150;   // start the long output hold-off here
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES    = 60;    // about the block's worst latency, with margin
  localparam int PRINT_LIMIT     = 40;

  typedef struct {
    logic signed [TEMP_W-1:0] temperature;
    logic        [PRES_W-1:0] pressure;
    logic signed [ALT_W-1:0]  altitude;
  } sample_t;

  typedef struct {
    logic signed [TEMP_W-1:0]    mean_temperature;
    logic        [PRES_W-1:0]    mean_pressure;
    logic signed [ALT_W-1:0]     mean_altitude;
    logic        [SAMPLES_W-1:0] samples_held;
  } average_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] temperature = '0;
  logic        [PRES_W-1:0] pressure = '0;
  logic signed [ALT_W-1:0]  altitude = '0;
  logic                     out_valid;
  logic                     burst_stall = 1'b0;
  logic                     hold_stall = 1'b0;
  wire                      out_stall = burst_stall | hold_stall;

  logic signed [TEMP_W-1:0]    mean_temperature;
  logic        [PRES_W-1:0]    mean_pressure;
  logic signed [ALT_W-1:0]     mean_altitude;
  logic        [SAMPLES_W-1:0] samples_held;

  sample_t  pending[$];          // requests still to be sent
  average_t expected_means[$];   // predicted results, oldest first

  // Predictor copy of the sample rings.
  logic signed [TEMP_W-1:0] temp_hist [RING_DEPTH];
  logic        [PRES_W-1:0] pres_hist [RING_DEPTH];
  logic signed [ALT_W-1:0]  alt_hist  [RING_DEPTH];
  int next_slot  = 0;
  int held_count = 0;

  int error_count       = 0;
  int accepted_requests = 0;
  int results_seen      = 0;
  int requests_seen     = 0;
  int quiet_from        = 0;
  int gap_left          = 0;
  int stall_left        = 0;
  int hold_count        = 0;
  bit hold_done         = 1'b0;
  int idle_cycles       = 0;

  sensor_moving_average #(
    .RING_DEPTH(RING_DEPTH)
  ) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .temperature      (temperature),
    .pressure         (pressure),
    .altitude         (altitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .mean_temperature (mean_temperature),
    .mean_pressure    (mean_pressure),
    .mean_altitude    (mean_altitude),
    .samples_held     (samples_held)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Store the sample, advance the slot, then average the slots held so far.
  // Signed longint division truncates toward zero, as the block does.
  function automatic average_t average_after(sample_t s);
    average_t r;
    longint   sum_temp;
    longint   sum_pres;
    longint   sum_alt;
    int       i;
    sum_temp = 0;
    sum_pres = 0;
    sum_alt  = 0;
    temp_hist[next_slot] = s.temperature;
    pres_hist[next_slot] = s.pressure;
    alt_hist[next_slot]  = s.altitude;
    next_slot = (next_slot + 1) % RING_DEPTH;
    if (held_count < RING_DEPTH) held_count++;
    // Slots 0..held_count-1 are exactly the ones written so far.
    for (i = 0; i < held_count; i++) begin
      sum_temp += longint'(temp_hist[i]);
      sum_pres += longint'(pres_hist[i]);
      sum_alt  += longint'(alt_hist[i]);
    end
    r.mean_temperature = TEMP_W'(sum_temp / held_count);
    r.mean_pressure    = PRES_W'(sum_pres / held_count);
    r.mean_altitude    = ALT_W'(sum_alt / held_count);
    r.samples_held     = held_count[SAMPLES_W-1:0];
    return r;
  endfunction

  task automatic add_request(int t, int p, int a);
    sample_t s;
    s.temperature = TEMP_W'(t);
    s.pressure    = PRES_W'(p);
    s.altitude    = ALT_W'(a);
    pending.push_back(s);
  endtask

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  // Driver: predict on every accepted request, hold a stalled request, and
  // otherwise either idle for a short burst or offer the next request.
  always @(posedge clk) begin : drive_requests
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_means.push_back(average_after(pending.pop_front()));
        accepted_requests++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0 && accepted_requests < quiet_from &&
                     $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          in_valid    <= 1'b1;
          temperature <= pending[0].temperature;
          pressure    <= pending[0].pressure;
          altitude    <= pending[0].altitude;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, then
  // pick the short random stall for the next cycle.
  always @(posedge clk) begin : check_means
    average_t want;
    if (rst) begin
      burst_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_means.size() == 0) begin
          report_mismatch("result arrived with no request waiting for it");
        end else begin
          want = expected_means.pop_front();
          if (mean_temperature !== want.mean_temperature)
            report_mismatch($sformatf("mean_temperature: got %0d, expected %0d",
                                      mean_temperature, want.mean_temperature));
          if (mean_pressure !== want.mean_pressure)
            report_mismatch($sformatf("mean_pressure: got %0d, expected %0d",
                                      mean_pressure, want.mean_pressure));
          if (mean_altitude !== want.mean_altitude)
            report_mismatch($sformatf("mean_altitude: got %0d, expected %0d",
                                      mean_altitude, want.mean_altitude));
          if (samples_held !== want.samples_held)
            report_mismatch($sformatf("samples_held: got %0d, expected %0d",
                                      samples_held, want.samples_held));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        burst_stall <= 1'b1;
      end else if (results_seen < quiet_from && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        burst_stall <= 1'b1;
      end else begin
        burst_stall <= 1'b0;
      end
    end
  end

  // Hold the output off once for a long stretch while requests keep coming.
  // This fills the output register and the block, so in_stall must rise.
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_stall <= 1'b0;
    end else begin
      if (in_valid && !in_stall) requests_seen++;
      if (hold_stall) begin
        hold_count++;
        if (hold_count == HOLD_CYCLES) hold_stall <= 1'b0;
      end else if (!hold_done && requests_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_count = 0;
        hold_stall <= 1'b1;
      end
    end
  end

  // Give up if no request and no result moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_test
    int k;
    int len;
    int t;
    int p;
    int a;

    // Directed part. Start with the field extremes as raw bit patterns, then
    // the stated ranges. Odd negative sums check truncation toward zero.
    // Twenty requests in total, so the ring fills and wraps, and the count
    // saturates at the ring depth.
    add_request(0, 0, 0);
    add_request(16383, 131071, 32767);
    add_request(-16384, 0, -32768);
    add_request(-1, 1, -1);
    add_request(-4000, 0, -2000);
    add_request(8500, 131071, 20000);
    for (k = 0; k < 14; k++)
      add_request(-(2 * k + 3), (k * 100003) % 131072, (k % 2) ? -7 : 5);

    // Random part. Mostly in-range samples, some raw bit patterns so that
    // every bit of every field toggles. Add an occasional run of one extreme
    // that is long enough to fill the whole ring.
    k = 0;
    while (k < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 40) == 0) begin
        len = RING_DEPTH + 2;
        t = $urandom_range(0, 1) ? 16383 : -16384;
        p = $urandom_range(0, 1) ? 131071 : 0;
        a = $urandom_range(0, 1) ? 32767 : -32768;
        repeat (len) add_request(t, p, a);
        k += len;
      end else if ($urandom_range(0, 3) == 0) begin
        add_request($urandom, $urandom, $urandom);
        k++;
      end else begin
        add_request(int'($urandom_range(0, 12500)) - 4000, $urandom_range(0, 131071),
                    int'($urandom_range(0, 22000)) - 2000);
        k++;
      end
    end
    quiet_from = pending.size() - QUIET_TAIL;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to be taken and every result to come back.
    while (pending.size() != 0 || in_valid) @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_means.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sensor_moving_average.f
+incdir+hdl
hdl/sma_pkg.sv
hdl/sma_div.sv
hdl/sma_ctrl.sv
hdl/sma_datapath.sv
hdl/sensor_moving_average.sv
tb/sensor_moving_average_test.sv
